// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_CHANGE = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2,
        OP_REMOVE = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } t_entry;

    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } t_cmd;

endpackage

// ===== rtl/core/spq_cell.sv =====
module spq_cell
    import spq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  t_entry i_left,
    input  logic   i_left_ge,
    input  t_entry i_right,
    input  logic   i_seen,
    output t_entry o_entry,
    output logic   o_ge,
    output logic   o_seen
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_match;

    assign o_ge    = r_entry.valid && (r_entry.prio >= i_cmd.prio);
    assign w_match = r_entry.valid && (r_entry.value == i_cmd.value)
                     && (r_entry.prio == i_cmd.prio);
    assign o_seen  = i_seen || w_match;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            OP_INSERT: begin
                // The new entry lands in the first cell that is empty or whose priority is lower.
                if (!o_ge) begin
                    if (i_left_ge) begin
                        n_entry.valid = 1'b1;
                        n_entry.value = i_cmd.value;
                        n_entry.prio  = i_cmd.prio;
                    end else begin
                        n_entry = i_left;
                    end
                end
            end
            OP_POP: begin
                n_entry = i_right;
            end
            OP_REMOVE: begin
                // Cells at and behind the first match close the gap.
                if (o_seen) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry.value <= n_entry.value;
        r_entry.prio  <= n_entry.prio;
    end

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// Channel | Direction | Handshake             | Fields
// request | in        | start high, busy low  | kind, item_value, item_priority, new_priority
// result  | out       | o_done, one cycle     | status, out_value, out_priority, entry_count, is_empty
//
// Insert, pop, an unused kind and a change that finds no entry make a single pass; the result
// strobes in the cycle after acceptance.
// A change that finds its entry makes a remove pass through the cell row, then a reinsert
// pass, during which busy is high. The result follows the second pass.
// Reset clears every cell's valid bit and the count.
// The receiver cannot stall; each result is shown for exactly one cycle.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_item_value,
    input  logic signed [15:0] i_item_priority,
    input  logic signed [15:0] i_new_priority,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_out_value,
    output logic signed [15:0] o_out_priority,
    output logic [4:0]         o_entry_count,
    output logic               o_is_empty
);

    typedef enum logic [1:0] {
        S_IDLE     = 2'b01,
        S_REINSERT = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_done, n_done;
    logic [1:0]         r_status, n_status;
    logic signed [31:0] r_out_value, n_out_value;
    logic signed [15:0] r_out_priority, n_out_priority;
    logic signed [31:0] r_hold_value, n_hold_value;
    logic signed [15:0] r_hold_prio, n_hold_prio;

    t_cmd   w_cmd;
    t_entry w_entry [CAPACITY];
    logic   w_ge    [CAPACITY];
    logic   w_seen  [CAPACITY+1];
    logic [CAPACITY-1:0] w_valid;
    logic   w_accept;
    logic   w_full;
    logic   w_empty;

    assign busy     = (r_state == S_REINSERT);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == COUNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_seen[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_ge;
        if (g == 0) begin : g_head
            assign w_left    = '0;
            assign w_left_ge = 1'b1;
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_left_ge = w_ge[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end
        assign w_valid[g] = w_entry[g].valid;

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_left    (w_left),
            .i_left_ge (w_left_ge),
            .i_right   (w_right),
            .i_seen    (w_seen[g]),
            .o_entry   (w_entry[g]),
            .o_ge      (w_ge[g]),
            .o_seen    (w_seen[g+1])
        );
    end

    always_comb begin
        w_cmd.op       = OP_HOLD;
        w_cmd.value    = i_item_value;
        w_cmd.prio     = i_item_priority;
        n_state        = r_state;
        n_count        = r_count;
        n_done         = 1'b0;
        n_status       = STATUS_OK;
        n_out_value    = '0;
        n_out_priority = '0;
        n_hold_value   = r_hold_value;
        n_hold_prio    = r_hold_prio;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_done = 1'b1;
                    case (i_kind)
                        KIND_INSERT: begin
                            if (w_full) begin
                                n_status = STATUS_FULL;
                            end else begin
                                w_cmd.op = OP_INSERT;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        KIND_POP: begin
                            if (w_empty) begin
                                n_status = STATUS_EMPTY;
                            end else begin
                                w_cmd.op       = OP_POP;
                                n_count        = r_count - 1'b1;
                                n_out_value    = w_entry[0].value;
                                n_out_priority = w_entry[0].prio;
                            end
                        end
                        KIND_CHANGE: begin
                            w_cmd.op = OP_REMOVE;
                            if (w_seen[CAPACITY]) begin
                                // The result waits for the reinsert pass.
                                n_done       = 1'b0;
                                n_state      = S_REINSERT;
                                n_count      = r_count - 1'b1;
                                n_hold_value = i_item_value;
                                n_hold_prio  = i_new_priority;
                            end else begin
                                n_status = STATUS_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_status = STATUS_OK;
                        end
                    endcase
                end
            end
            S_REINSERT: begin
                w_cmd.op    = OP_INSERT;
                w_cmd.value = r_hold_value;
                w_cmd.prio  = r_hold_prio;
                n_count     = r_count + 1'b1;
                n_done      = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status       <= n_status;
        r_out_value    <= n_out_value;
        r_out_priority <= n_out_priority;
        r_hold_value   <= n_hold_value;
        r_hold_prio    <= n_hold_prio;
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_out_value    = r_out_value;
    assign o_out_priority = r_out_priority;
    assign o_entry_count  = 5'(r_count);
    assign o_is_empty     = (r_count == '0);

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("count differs from number of valid cells");

    a_cells_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("valid cells are not packed at the head");

    a_reinsert_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REINSERT) |=> (r_state == S_IDLE) && o_done)
        else $error("reinsert pass did not finish in one cycle");

    a_reinsert_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REINSERT) |-> !w_full)
        else $error("reinsert pass on a full queue");

endmodule

// ===== sim/spq_checker.sv =====
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_item_value,
    input  logic signed [15:0] i_item_priority,
    input  logic signed [15:0] i_new_priority,
    input  logic               i_done,
    input  logic [1:0]         i_status,
    input  logic signed [31:0] i_out_value,
    input  logic signed [15:0] i_out_priority,
    input  logic [4:0]         i_entry_count,
    input  logic               i_is_empty,
    output int                 o_mismatches,
    output int                 o_outstanding
);

    typedef struct {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } t_slot;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic signed [15:0] prio;
        logic [4:0]         count;
        logic               empty;
    } t_outcome;

    // Mirror of the queue contents, head first.
    t_slot    ordered_slots[$];
    t_outcome awaited_outcomes[$];
    int       mismatch_count = 0;

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, want, got);
        end
    endfunction

    // New entries go behind every entry of greater or equal priority.
    function automatic void place_slot(logic signed [31:0] value, logic signed [15:0] prio);
        t_slot s;
        int    pos;
        s.value = value;
        s.prio  = prio;
        pos     = 0;
        while (pos < ordered_slots.size() && ordered_slots[pos].prio >= prio) begin
            pos++;
        end
        ordered_slots.insert(pos, s);
    endfunction

    function automatic t_outcome apply_request(logic [1:0] kind, logic signed [31:0] value,
                                               logic signed [15:0] prio,
                                               logic signed [15:0] new_prio);
        t_outcome r;
        int       hit;
        r.status = STATUS_OK;
        r.value  = '0;
        r.prio   = '0;
        hit      = -1;
        case (kind)
            KIND_INSERT: begin
                if (ordered_slots.size() >= CAPACITY) begin
                    r.status = STATUS_FULL;
                end else begin
                    place_slot(value, prio);
                end
            end
            KIND_POP: begin
                if (ordered_slots.size() == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    r.value = ordered_slots[0].value;
                    r.prio  = ordered_slots[0].prio;
                    ordered_slots.delete(0);
                end
            end
            KIND_CHANGE: begin
                for (int i = 0; i < ordered_slots.size(); i++) begin
                    if (hit < 0 && ordered_slots[i].value == value
                        && ordered_slots[i].prio == prio) begin
                        hit = i;
                    end
                end
                // Removal comes first, so a change on a full queue still succeeds.
                if (hit < 0) begin
                    r.status = STATUS_NOT_FOUND;
                end else begin
                    ordered_slots.delete(hit);
                    place_slot(value, new_prio);
                end
            end
            default: begin
            end
        endcase
        r.count = 5'(ordered_slots.size());
        r.empty = (ordered_slots.size() == 0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (i_done) begin
                if (awaited_outcomes.size() == 0) begin
                    note_mismatch("unexpected result", '0, {30'd0, i_status});
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (i_status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(i_status));
                    if (i_out_value !== want.value)
                        note_mismatch("out_value", want.value, i_out_value);
                    if (i_out_priority !== want.prio)
                        note_mismatch("out_priority", 32'(want.prio), 32'(i_out_priority));
                    if (i_entry_count !== want.count)
                        note_mismatch("entry_count", 32'(want.count), 32'(i_entry_count));
                    if (i_is_empty !== want.empty)
                        note_mismatch("is_empty", 32'(want.empty), 32'(i_is_empty));
                end
            end
            if (i_start && !i_busy) begin
                awaited_outcomes.push_back(apply_request(i_kind, i_item_value,
                                                         i_item_priority, i_new_priority));
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= awaited_outcomes.size();
    end

endmodule

// ===== sim/sorted_priority_queue_test.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         RANDOM_REQUESTS = 1600;

    typedef struct {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } t_pair;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               start           = 1'b0;
    logic               busy;
    logic [1:0]         i_kind          = KIND_INSERT;
    logic signed [31:0] i_item_value    = '0;
    logic signed [15:0] i_item_priority = '0;
    logic signed [15:0] i_new_priority  = '0;
    logic               o_done;
    logic [1:0]         o_status;
    logic signed [31:0] o_out_value;
    logic signed [15:0] o_out_priority;
    logic [4:0]         o_entry_count;
    logic               o_is_empty;

    int    mismatches;
    int    outstanding;
    int    idle_cycles = 0;
    bit    no_gaps     = 1'b0;
    t_pair recent_pairs[$];

    sorted_priority_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .i_new_priority  (i_new_priority),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_out_value     (o_out_value),
        .o_out_priority  (o_out_priority),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty)
    );

    spq_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_kind          (i_kind),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .i_new_priority  (i_new_priority),
        .i_done          (o_done),
        .i_status        (o_status),
        .i_out_value     (o_out_value),
        .i_out_priority  (o_out_priority),
        .i_entry_count   (o_entry_count),
        .i_is_empty      (o_is_empty),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Start stays high between back-to-back requests; it only drops when a gap is drawn.
    task automatic send_request(logic [1:0] kind, logic signed [31:0] value,
                                logic signed [15:0] prio, logic signed [15:0] new_prio);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_kind          <= kind;
        i_item_value    <= value;
        i_item_priority <= prio;
        i_new_priority  <= new_prio;
        do @(posedge i_clk); while (busy);
    endtask

    // Mostly a handful of small values so that ties and matches are common.
    function automatic logic signed [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) return $urandom_range(0, 7) - 3;
        if (roll < 9) return $urandom();
        return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endfunction

    function automatic logic signed [15:0] pick_prio();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) return 16'($urandom_range(0, 4) - 2);
        if (roll < 9) return 16'($urandom());
        return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endfunction

    function automatic void remember_pair(logic signed [31:0] value, logic signed [15:0] prio);
        t_pair p;
        p.value = value;
        p.prio  = prio;
        recent_pairs.push_back(p);
        if (recent_pairs.size() > 24) recent_pairs.delete(0);
    endfunction

    initial begin
        int                 roll;
        int                 insert_pct;
        t_pair              p;
        logic signed [31:0] value;
        logic signed [15:0] prio;
        logic signed [15:0] new_prio;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(KIND_POP, '0, '0, '0);
        send_request(KIND_UNUSED, '1, '1, '1);
        send_request(KIND_CHANGE, 32'sd5, 16'sd0, 16'sd1);
        send_request(KIND_INSERT, 32'sh7fff_ffff, 16'sh7fff, '0);
        send_request(KIND_INSERT, 32'sh8000_0000, 16'sh8000, '0);
        send_request(KIND_INSERT, 32'sd0, 16'sd0, '0);
        send_request(KIND_INSERT, -32'sd1, -16'sd1, '0);
        send_request(KIND_INSERT, 32'sd5, 16'sd0, '0);
        send_request(KIND_INSERT, 32'sd6, 16'sd0, '0);
        send_request(KIND_INSERT, 32'sd1, 16'sd100, '0);
        send_request(KIND_INSERT, 32'sd2, -16'sd100, '0);
        send_request(KIND_INSERT, 32'sd3, 16'sd0, '0);
        send_request(KIND_INSERT, 32'sd4, 16'sh7fff, '0);
        send_request(KIND_INSERT, 32'sd7, 16'sh8000, '0);
        send_request(KIND_INSERT, 32'sd8, 16'sd1, '0);
        send_request(KIND_INSERT, 32'sd9, -16'sd1, '0);
        send_request(KIND_INSERT, 32'sd10, 16'sd2, '0);
        send_request(KIND_INSERT, 32'sd11, 16'sd3, '0);
        send_request(KIND_INSERT, 32'sd12, 16'sd4, '0);
        // The queue is now full.
        send_request(KIND_INSERT, 32'sd13, 16'sd5, '0);
        send_request(KIND_CHANGE, 32'sd5, 16'sd0, 16'sh7fff);
        send_request(KIND_CHANGE, 32'sd0, 16'sd0, 16'sh8000);
        send_request(KIND_CHANGE, 32'sd5, 16'sd0, 16'sd9);
        repeat (3) send_request(KIND_POP, '0, '0, '0);

        insert_pct = 50;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            // Swing the fill level between empty and full, with some bursts at full rate.
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 75;
                    1: insert_pct = 50;
                    default: insert_pct = 25;
                endcase
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            roll     = $urandom_range(0, 99);
            value    = pick_value();
            prio     = pick_prio();
            new_prio = pick_prio();
            if (roll < 3) begin
                send_request(KIND_UNUSED, $urandom(), 16'($urandom()), 16'($urandom()));
            end else if (roll < 23) begin
                if (recent_pairs.size() > 0 && $urandom_range(0, 3) != 0) begin
                    p     = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
                    value = p.value;
                    prio  = p.prio;
                end
                send_request(KIND_CHANGE, value, prio, new_prio);
                remember_pair(value, new_prio);
            end else if ($urandom_range(0, 99) < insert_pct) begin
                send_request(KIND_INSERT, value, prio, new_prio);
                remember_pair(value, prio);
            end else begin
                send_request(KIND_POP, value, prio, new_prio);
            end
        end
        start <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
